// ===== hdl/http_url_splitter_top_macros.svh =====
// Assertion macros shared by the URL splitter modules.
// Expects clk and rst in the scope of every use.
`ifndef HTTP_URL_SPLITTER_TOP_MACROS_SVH
`define HTTP_URL_SPLITTER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define HUS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define HUS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hus_pkg.sv =====
// Package for the URL splitter: constants, phase and error codes, scan state types
// and the authority check shared by the scanner and the result formatter.
package hus_pkg;

  localparam int MAX_URL_BYTES_DEF = 32768;

  localparam logic [2:0] PH_SCHEME = 3'd0;
  localparam logic [2:0] PH_AUTH   = 3'd1;
  localparam logic [2:0] PH_PATH   = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_FAIL   = 3'd4;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_LENGTH     = 4'd1;
  localparam logic [3:0] ERR_NOT_ABS    = 4'd2;
  localparam logic [3:0] ERR_SCHEME     = 4'd3;
  localparam logic [3:0] ERR_EMPTY_AUTH = 4'd4;
  localparam logic [3:0] ERR_BAD_CHAR   = 4'd5;
  localparam logic [3:0] ERR_IPV6       = 4'd6;
  localparam logic [3:0] ERR_AUTH       = 4'd7;
  localparam logic [3:0] ERR_BRACKETS   = 4'd8;
  localparam logic [3:0] ERR_NO_HOST    = 4'd9;
  localparam logic [3:0] ERR_PORT       = 4'd10;

  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_QMARK = "?";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_AT    = "@";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Position of the second slash of "://" for an empty, http and https scheme.
  localparam logic [15:0] SEP_EMPTY = 16'd2;
  localparam logic [15:0] SEP_HTTP  = 16'd6;
  localparam logic [15:0] SEP_HTTPS = 16'd7;
  localparam logic [2:0]  LEN_HTTP  = 3'd4;
  localparam logic [2:0]  LEN_HTTPS = 3'd5;

  localparam logic [2:0]  PORT_DIGITS  = 3'd5;
  localparam logic [2:0]  PORT_CNT_SAT = 3'd6;
  localparam logic [16:0] PORT_MAX     = 17'd65535;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  err_code;
    logic [2:0]  scheme_m;
    logic        https;
    logic [1:0]  sep;
    logic [15:0] auth_start;
    logic [15:0] host_start;
    logic [15:0] host_end;
    logic [15:0] path_start;
    logic [15:0] path_len;
    logic [16:0] port_acc;
    logic [2:0]  port_cnt;
    logic        ef_badchar;
    logic        ef_v6;
    logic        ef_auth;
    logic        ef_brk;
    logic        ef_nohost;
    logic        ef_nondigit;
    logic        bf_bracket;
    logic        bf_closed;
    logic        bf_port;
  } hus_state_t;

  typedef struct packed {
    hus_state_t  st;
    logic        len_err;
    logic [15:0] end_pos;
  } hus_snap_t;

  localparam hus_state_t ST_RESET = '0;

  function automatic logic [3:0] auth_check(hus_state_t s, logic [15:0] end_pos);
    logic [3:0] code;
    priority if (end_pos == s.auth_start) code = ERR_EMPTY_AUTH;
    else if (s.ef_badchar) code = ERR_BAD_CHAR;
    else if (s.bf_bracket && (!s.bf_closed || s.ef_v6)) code = ERR_IPV6;
    else if (s.bf_bracket && s.ef_auth) code = ERR_AUTH;
    else if (!s.bf_bracket && s.ef_brk) code = ERR_BRACKETS;
    else if (!s.bf_bracket && s.ef_nohost) code = ERR_NO_HOST;
    else if (s.bf_port && (s.port_cnt == 3'd0 || s.port_cnt > PORT_DIGITS ||
                           s.ef_nondigit || s.port_acc == 17'd0 ||
                           s.port_acc > PORT_MAX)) code = ERR_PORT;
    else code = ERR_NONE;
    return code;
  endfunction

endpackage

// ===== hdl/hus_ifs.sv =====
// Valid/ready channel interfaces of the URL splitter: byte requests in, results out.
// No dependencies.
interface hus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       no_char;
  logic       last_char;

  modport source(output valid, char_byte, no_char, last_char, input ready);
  modport sink(input valid, char_byte, no_char, last_char, output ready);
endinterface

interface hus_out_if;
  logic        valid;
  logic        ready;
  logic        url_ok;
  logic [3:0]  error_code;
  logic        is_https;
  logic [14:0] host_offset;
  logic [15:0] host_length;
  logic [15:0] port_number;
  logic        port_given;
  logic [15:0] path_offset;
  logic [15:0] path_length;
  logic        path_is_default;

  modport source(output valid, url_ok, error_code, is_https, host_offset, host_length,
                 port_number, port_given, path_offset, path_length, path_is_default,
                 input ready);
  modport sink(input valid, url_ok, error_code, is_https, host_offset, host_length,
               port_number, port_given, path_offset, path_length, path_is_default,
               output ready);
endinterface

// ===== hdl/hus_scan.sv =====
// Byte scanner: updates the parse state for each request and hands a snapshot
// of the final state downstream on the last byte. Uses hus_pkg, hus_ifs and the macros.
`include "http_url_splitter_top_macros.svh"

module hus_scan #(
  parameter int MAX_URL_BYTES = hus_pkg::MAX_URL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hus_in_if.sink            url,
  output hus_pkg::hus_snap_t snap,
  output logic              snap_valid,
  input  logic              snap_ready
);
  import hus_pkg::*;

  localparam int CW = $clog2(MAX_URL_BYTES + 2);

  hus_state_t  st;
  hus_state_t  nx;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_next;
  logic [15:0] p;
  logic [7:0]  b;
  logic [7:0]  low;
  logic [2:0]  m_new;
  logic [3:0]  code;
  logic        take;
  logic        acc;
  logic        found;
  logic        term;
  logic        rel0;
  logic        len_err;

  function automatic logic [7:0] https_char(logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0: c = "h";
      3'd1: c = "t";
      3'd2: c = "t";
      3'd3: c = "p";
      3'd4: c = "s";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic hus_state_t port_byte(hus_state_t s, logic [7:0] c);
    hus_state_t r;
    r = s;
    if (s.port_cnt < PORT_CNT_SAT) r.port_cnt = s.port_cnt + 3'd1;
    if (c < CH_ZERO || c > CH_NINE) begin
      r.ef_nondigit = 1'b1;
    end else if (r.port_cnt <= PORT_DIGITS) begin
      r.port_acc = (s.port_acc << 3) + (s.port_acc << 1) + 17'(c - CH_ZERO);
    end
    return r;
  endfunction

  assign url.ready = !rst && (!snap_valid || snap_ready);
  assign acc = url.valid && url.ready;
  assign b = url.char_byte;
  assign p = 16'(pos);
  assign take = !url.no_char && (pos < CW'(MAX_URL_BYTES));
  assign pos_next = (acc && !url.no_char && pos <= CW'(MAX_URL_BYTES)) ? pos + 1'b1 : pos;
  assign len_err = (pos_next == '0) || (pos_next > CW'(MAX_URL_BYTES));
  assign low = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_BIT : b;
  assign term = (b == CH_SLASH) || (b == CH_QMARK) || (b == CH_HASH);
  assign rel0 = (p == st.auth_start);
  assign found = (b == CH_SLASH) && st.sep[1];
  assign m_new = (st.scheme_m == p[2:0] && p < 16'd5 && low == https_char(p[2:0])) ?
                 st.scheme_m + 3'd1 : st.scheme_m;
  assign code = auth_check(st, p);

  always_comb begin
    nx = st;
    if (take) begin
      unique case (st.phase)
        PH_SCHEME: begin
          nx.scheme_m = m_new;
          nx.sep = {(b == CH_SLASH) && st.sep[0], b == CH_COLON};
          if (found) begin
            if (p == SEP_EMPTY) begin
              nx.phase = PH_FAIL;
              nx.err_code = ERR_NOT_ABS;
            end else if ((p == SEP_HTTP && m_new >= LEN_HTTP) ||
                         (p == SEP_HTTPS && m_new >= LEN_HTTPS)) begin
              if (p == SEP_HTTPS) nx.https = 1'b1;
              nx.phase = PH_AUTH;
              nx.auth_start = p + 16'd1;
              nx.host_start = p + 16'd1;
              nx.host_end = 16'd0;
            end else begin
              nx.phase = PH_FAIL;
              nx.err_code = ERR_SCHEME;
            end
          end
        end
        PH_AUTH: begin
          if (term) begin
            if (code != ERR_NONE) begin
              nx.phase = PH_FAIL;
              nx.err_code = code;
            end else begin
              if (!st.bf_bracket && !st.bf_port) nx.host_end = p;
              nx.path_start = p;
              nx.path_len = (b == CH_SLASH) ? 16'd1 : 16'd0;
              nx.phase = (b == CH_SLASH) ? PH_PATH : PH_DONE;
            end
          end else begin
            if (b <= CH_SPACE || b >= CH_DEL || b == CH_AT) nx.ef_badchar = 1'b1;
            if (rel0 && b == CH_LBRK) begin
              nx.bf_bracket = 1'b1;
              nx.host_start = p + 16'd1;
              nx.host_end = 16'd0;
            end else if (st.bf_bracket) begin
              if (!st.bf_closed) begin
                if (b == CH_RBRK) begin
                  nx.bf_closed = 1'b1;
                  nx.host_end = p;
                  if (p == st.host_start) nx.ef_v6 = 1'b1;
                end
              end else if (st.bf_port) begin
                nx = port_byte(nx, b);
              end else if ({1'b0, p} == {1'b0, st.host_end} + 17'd1) begin
                if (b == CH_COLON) nx.bf_port = 1'b1;
                else nx.ef_auth = 1'b1;
              end
            end else if (b == CH_COLON && !st.bf_port) begin
              nx.bf_port = 1'b1;
              nx.host_end = p;
              if (rel0) nx.ef_nohost = 1'b1;
            end else begin
              if (b == CH_COLON) nx.ef_brk = 1'b1;
              if (st.bf_port) nx = port_byte(nx, b);
            end
          end
        end
        PH_PATH: begin
          if (b == CH_QMARK || b == CH_HASH) nx.phase = PH_DONE;
          else nx.path_len = st.path_len + 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
      pos <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (acc && url.last_char) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (acc) begin
        if (url.last_char) begin
          st <= ST_RESET;
          pos <= '0;
        end else begin
          st <= nx;
          pos <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && url.last_char) begin
      snap.st <= nx;
      snap.len_err <= len_err;
      snap.end_pos <= 16'(pos_next);
    end
  end

  `HUS_ASSERT_NXT(a_last_gives_snap, acc && url.last_char, snap_valid, "last byte lost")
  `HUS_ASSERT_NXT(a_last_clears, acc && url.last_char,
    pos == '0 && st.phase == PH_SCHEME, "state not cleared after last byte")
  `HUS_ASSERT_IMP(a_fail_has_code, st.phase == PH_FAIL, st.err_code != ERR_NONE,
    "failed parse without an error code")

endmodule

// ===== hdl/hus_fmt.sv =====
// Result formatter: closes an open authority, resolves the error code and
// registers the result fields. Uses hus_pkg, hus_ifs and the macros.
`include "http_url_splitter_top_macros.svh"

module hus_fmt (
  input  logic               clk,
  input  logic               rst,
  input  hus_pkg::hus_snap_t snap,
  input  logic               snap_valid,
  output logic               snap_ready,
  hus_out_if.source          res
);
  import hus_pkg::*;

  hus_state_t  s;
  logic [3:0]  code;
  logic [15:0] host_end_f;
  logic [15:0] path_start_f;
  logic [15:0] path_len_f;
  logic        ok;
  logic        load;
  logic        res_valid;

  logic        r_ok;
  logic [3:0]  r_code;
  logic        r_https;
  logic [14:0] r_host_off;
  logic [15:0] r_host_len;
  logic [15:0] r_port;
  logic        r_port_given;
  logic [15:0] r_path_off;
  logic [15:0] r_path_len;
  logic        r_path_def;

  assign s = snap.st;
  assign snap_ready = !res_valid || res.ready;
  assign load = snap_valid && snap_ready;

  always_comb begin
    host_end_f = s.host_end;
    path_start_f = s.path_start;
    path_len_f = s.path_len;
    if (snap.len_err) begin
      code = ERR_LENGTH;
    end else begin
      unique case (s.phase)
        PH_SCHEME: code = ERR_NOT_ABS;
        PH_AUTH: begin
          code = auth_check(s, snap.end_pos);
          if (!s.bf_bracket && !s.bf_port) host_end_f = snap.end_pos;
          path_start_f = snap.end_pos;
          path_len_f = 16'd0;
        end
        PH_FAIL: code = s.err_code;
        default: code = ERR_NONE;
      endcase
    end
  end

  assign ok = (code == ERR_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_ok <= ok;
      r_code <= code;
      r_https <= ok && s.https;
      r_host_off <= ok ? s.host_start[14:0] : 15'd0;
      r_host_len <= ok ? host_end_f - s.host_start : 16'd0;
      r_port <= (ok && s.bf_port) ? s.port_acc[15:0] : 16'd0;
      r_port_given <= ok && s.bf_port;
      r_path_off <= ok ? path_start_f : 16'd0;
      r_path_len <= ok ? path_len_f : 16'd0;
      r_path_def <= ok && (path_len_f == 16'd0);
    end
  end

  assign res.valid = res_valid;
  assign res.url_ok = r_ok;
  assign res.error_code = r_code;
  assign res.is_https = r_https;
  assign res.host_offset = r_host_off;
  assign res.host_length = r_host_len;
  assign res.port_number = r_port;
  assign res.port_given = r_port_given;
  assign res.path_offset = r_path_off;
  assign res.path_length = r_path_len;
  assign res.path_is_default = r_path_def;

  `HUS_ASSERT_NXT(a_snap_to_result, load, res.valid, "snapshot taken without a result")
  `HUS_ASSERT_IMP(a_ok_no_code, res.valid && res.url_ok, res.error_code == ERR_NONE, "valid URL with an error code")
  `HUS_ASSERT_IMP(a_err_zero_fields, res.valid && !res.url_ok, res.error_code != ERR_NONE && !res.port_given && res.path_length == 16'd0, "failed URL with fields set")

endmodule

// ===== hdl/http_url_splitter_top.sv =====
// URL splitter top level: one byte request per cycle, back to back while results
// are taken, through a state-update stage and a result register. A result passes
// the snapshot and result registers after the request that carries last_char; the
// next URL may follow directly. Result-side stalls hold the snapshot, then the byte
// requests. Synchronous reset rst clears the parse state and both valid flags and
// holds ready low. Depends on hus_pkg, hus_ifs, hus_scan and hus_fmt.
module http_url_splitter_top #(
  parameter int MAX_URL_BYTES = hus_pkg::MAX_URL_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hus_in_if.sink    url,
  hus_out_if.source res
);
  import hus_pkg::*;

  hus_snap_t snap;
  logic      snap_valid;
  logic      snap_ready;

  hus_scan #(
    .MAX_URL_BYTES(MAX_URL_BYTES)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .url(url),
    .snap(snap),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready)
  );

  hus_fmt u_fmt (
    .clk(clk),
    .rst(rst),
    .snap(snap),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .res(res)
  );

endmodule
